// ===== rtl/fda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fda_pkg
// Shared constants, types and state codes of the fixed-point to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package fda_pkg;

   localparam int MAX_FRAC_DEFAULT = 10;

   localparam int VALUE_W  = 64;
   localparam int INT_W    = 32;
   localparam int FRAC_W   = 32;
   localparam int PREC_W   = 5;
   localparam int DIG_W    = 4;
   localparam int BCD_DIGS = 10;
   localparam int BCD_W    = BCD_DIGS * DIG_W;
   localparam int CNT_W    = 4;
   localparam int CHAR_W   = 8;

   localparam logic [INT_W-1:0] INT_SAT     = 32'h7FFF_FFFF;
   localparam logic [BCD_W-1:0] INT_SAT_BCD = 40'h21_4748_3647;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [PREC_W-1:0] PREC_RESET = 5'd2;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CONV  = 4'b0010,
      S_ROUND = 4'b0100,
      S_LOAD  = 4'b1000
   } seq_state_type;

   typedef enum logic [4:0] {
      E_IDLE  = 5'b00001,
      E_SIGN  = 5'b00010,
      E_INT   = 5'b00100,
      E_POINT = 5'b01000,
      E_FRAC  = 5'b10000
   } emit_state_type;

   // job handed from the sequencer to the character emitter
   typedef struct packed {
      logic             neg;
      logic [CNT_W-1:0] int_len;
      logic [CNT_W-1:0] frac_len;
   } emit_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/fda_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fda_req_if
// Valid/ready channel carrying one Q31.32 value per transfer.
// ----------------------------------------------------------------------------
interface fda_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/fda_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fda_rsp_if
// Valid/ready channel carrying one ASCII character per transfer.
// ----------------------------------------------------------------------------
interface fda_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/fda_bin2bcd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fda_bin2bcd
// Iterative binary to BCD converter, one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module fda_bin2bcd
   import fda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [INT_W-1:0] bin,
   output logic             done,
   output logic [BCD_W-1:0] bcd
);

   localparam int StepW = $clog2(INT_W + 1);

   logic [INT_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [StepW-1:0] cnt_ff, cnt_in;
   logic [BCD_W-1:0] adj;

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      for (int k = 0; k < BCD_DIGS; k++) begin
         adj[k*DIG_W +: DIG_W] = (bcd_ff[k*DIG_W +: DIG_W] >= 4'd5)
                               ? bcd_ff[k*DIG_W +: DIG_W] + 4'd3
                               : bcd_ff[k*DIG_W +: DIG_W];
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (start) begin
         bin_in = bin;
         bcd_in = '0;
         cnt_in = StepW'(INT_W);
      end else if (cnt_ff != '0) begin
         bin_in = {bin_ff[INT_W-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[INT_W-1]};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = (cnt_ff == '0);
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

// ===== rtl/fda_frac_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fda_frac_gen
// Fraction digit generator: multiply the remainder by ten, one digit a cycle.
// ----------------------------------------------------------------------------
module fda_frac_gen
   import fda_pkg::*;
#(
   parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DEFAULT
)
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [FRAC_W-1:0]                     rem,
   output logic                                  done,
   output logic [(MAX_FRACTION_DIGITS+1)*DIG_W-1:0] digits
);

   // one guard digit beyond the longest precision decides rounding
   localparam int NDig  = MAX_FRACTION_DIGITS + 1;
   localparam int StepW = $clog2(NDig + 1);

   logic [FRAC_W-1:0]       rem_ff, rem_in;
   logic [NDig*DIG_W-1:0]   dig_ff, dig_in;
   logic [StepW-1:0]        cnt_ff, cnt_in;
   logic [FRAC_W+3:0]       prod;

   assign prod = {rem_ff, 3'b000} + {2'b00, rem_ff, 1'b0};

   always_comb begin
      rem_in = rem_ff;
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = rem;
         cnt_in = StepW'(NDig);
      end else if (cnt_ff != '0) begin
         rem_in = prod[FRAC_W-1:0];
         dig_in = {dig_ff[NDig*DIG_W-DIG_W-1:0], prod[FRAC_W+3:FRAC_W]};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dig_ff <= dig_in;
   end

   assign done   = (cnt_ff == '0);
   assign digits = dig_ff;

endmodule

`default_nettype wire

// ===== rtl/fda_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fda_emit
// Character serializer: sign, integer digits, point, fraction digits, into
// an output register.
// ----------------------------------------------------------------------------
module fda_emit
   import fda_pkg::*;
#(
   parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DEFAULT
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  emit_ctl_type                         ctl,
   input  logic [BCD_W-1:0]                     int_bcd,
   input  logic [MAX_FRACTION_DIGITS*DIG_W-1:0] frac_bcd,
   output logic                                 busy,
   fda_rsp_if.source                            rsp_if
);

   localparam int FracW = MAX_FRACTION_DIGITS * DIG_W;

   emit_state_type     state_ff, state_in;
   logic [BCD_W-1:0]   int_ff, int_in;
   logic [FracW-1:0]   frac_ff, frac_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic               out_free;
   logic [DIG_W-1:0]   int_dig;

   assign out_free = !valid_ff || rsp_if.ready;
   assign int_dig  = int_ff[{idx_ff, 2'b00} +: DIG_W];

   always_comb begin
      state_in = state_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      valid_in = valid_ff && !rsp_if.ready;
      char_in  = char_ff;
      last_in  = last_ff;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               int_in   = int_bcd;
               frac_in  = frac_bcd;
               idx_in   = ctl.int_len - 1'b1;
               left_in  = ctl.frac_len;
               state_in = ctl.neg ? E_SIGN : E_INT;
            end
         end
         E_SIGN: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = E_INT;
            end
         end
         E_INT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {4'd0, int_dig};
               last_in  = (idx_ff == '0) && (left_ff == '0);
               if (idx_ff == '0) begin
                  state_in = (left_ff != '0) ? E_POINT : E_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         E_POINT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_POINT;
               last_in  = 1'b0;
               state_in = E_FRAC;
            end
         end
         E_FRAC: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {4'd0, frac_ff[FracW-1 -: DIG_W]};
               last_in  = (left_ff == 4'd1);
               frac_in  = frac_ff << DIG_W;
               left_in  = left_ff - 1'b1;
               if (left_ff == 4'd1) begin
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      int_ff  <= int_in;
      frac_ff <= frac_in;
      idx_ff  <= idx_in;
      left_ff <= left_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy             = (state_ff != E_IDLE);
   assign rsp_if.valid     = valid_ff;
   assign rsp_if.character = char_ff;
   assign rsp_if.last      = last_ff;

endmodule

`default_nettype wire

// ===== rtl/fixed_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_top
// Converts a signed Q31.32 value into its decimal ASCII text, one
// character per transfer on the response channel.
// ----------------------------------------------------------------------------
// Each request transfer carries one Q31.32 value; the response channel
// returns its text: an optional '-', the integer digits ('0' for a zero
// integer part), then '.' and p fraction digits when p is nonzero, with
// last set on the final character. p comes from the csr precision register
// (reset 2, clamped to MAX_FRACTION_DIGITS; a negative value picks 6..0 by
// the decade of the integer part). A value is captured, then converted by
// the shift-and-add-3 binary to BCD unit (32 steps; the times-ten fraction
// unit runs alongside it for MAX_FRACTION_DIGITS+1 steps), then rounded and
// handed off; no new value is taken before the hand-off. Characters then
// leave at one per cycle from the output register while the response side
// takes them, and the next value is already being converted meanwhile; a
// text has at most 22 characters. A stalled response side holds the
// hand-off until the emitter is free. Precision may only be written while
// no text is in flight.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_top
   import fda_pkg::*;
#(
   parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   fda_req_if.sink           req_if,
   fda_rsp_if.source         rsp_if,
   input  logic              csr_we,
   input  logic [PREC_W-1:0] csr_wdata
);

   localparam int NDig  = MAX_FRACTION_DIGITS + 1;
   localparam int FracW = MAX_FRACTION_DIGITS * DIG_W;
   localparam int PW    = $clog2(NDig);

   // --- control and payload registers --------------------------------------
   seq_state_type      state_ff, state_in;
   logic [PREC_W-1:0]  prec_ff, prec_in;
   logic               neg_ff;
   logic [INT_W-1:0]   ipart_ff;
   logic [CNT_W-1:0]   p_ff;
   logic [BCD_W-1:0]   rnd_int_ff, rnd_int_in;
   logic [FracW-1:0]   rnd_frac_ff, rnd_frac_in;

   logic               accept;
   logic [VALUE_W-1:0] raw_val;
   logic [VALUE_W-1:0] mag;

   logic               bcd_done;
   logic [BCD_W-1:0]   bcd_val;
   logic               frac_done;
   logic [NDig*DIG_W-1:0] frac_dig;

   logic [2:0]         auto_p;
   logic [CNT_W-1:0]   raw_p;
   logic [CNT_W-1:0]   p_sel;

   logic [DIG_W-1:0]   d     [NDig];
   logic [DIG_W-1:0]   e     [BCD_DIGS];
   logic               round_up;
   logic               carry_int;
   logic               sat;
   logic               acc;

   logic [CNT_W-1:0]   int_len;
   logic               emit_busy;
   logic               emit_start;
   emit_ctl_type       emit_ctl;

   // --- request capture ----------------------------------------------------
   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign raw_val      = req_if.value;
   // magnitude of the most negative value is 2^63, which still fits unsigned
   assign mag          = raw_val[VALUE_W-1] ? (VALUE_W'(0) - raw_val) : raw_val;

   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff   <= raw_val[VALUE_W-1];
         ipart_ff <= mag[VALUE_W-1:FRAC_W];
      end
   end

   // --- shared iterative units ---------------------------------------------
   fda_bin2bcd u_bin2bcd (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .bin   (mag[VALUE_W-1:FRAC_W]),
      .done  (bcd_done),
      .bcd   (bcd_val)
   );

   fda_frac_gen #(
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_frac_gen (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .rem    (mag[FRAC_W-1:0]),
      .done   (frac_done),
      .digits (frac_dig)
   );

   // --- precision selection (settled during conversion) --------------------
   always_comb begin
      if (ipart_ff < 32'd1) begin
         auto_p = 3'd6;
      end else if (ipart_ff < 32'd10) begin
         auto_p = 3'd5;
      end else if (ipart_ff < 32'd100) begin
         auto_p = 3'd4;
      end else if (ipart_ff < 32'd1000) begin
         auto_p = 3'd3;
      end else if (ipart_ff < 32'd10000) begin
         auto_p = 3'd2;
      end else if (ipart_ff < 32'd100000) begin
         auto_p = 3'd1;
      end else begin
         auto_p = 3'd0;
      end
      raw_p = prec_ff[PREC_W-1] ? {1'b0, auto_p} : prec_ff[CNT_W-1:0];
      p_sel = (raw_p > CNT_W'(MAX_FRACTION_DIGITS)) ? CNT_W'(MAX_FRACTION_DIGITS)
                                                    : raw_p;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CONV) begin
         p_ff <= p_sel;
      end
   end

   // --- rounding and saturation --------------------------------------------
   // d[0] is the first fraction digit; d[p] is the guard digit. The guard
   // digit is 5 or more exactly when the dropped remainder is half or more.
   always_comb begin
      for (int k = 0; k < NDig; k++) begin
         d[k] = frac_dig[(NDig-1-k)*DIG_W +: DIG_W];
      end
      for (int k = 0; k < BCD_DIGS; k++) begin
         e[k] = bcd_val[k*DIG_W +: DIG_W];
      end

      round_up = (p_ff != '0) && (d[p_ff[PW-1:0]] >= 4'd5);

      // fraction increment: a digit bumps when every kept digit after it is 9
      acc = 1'b1;
      rnd_frac_in = '0;
      for (int k = MAX_FRACTION_DIGITS - 1; k >= 0; k--) begin
         if (round_up && acc) begin
            rnd_frac_in[(MAX_FRACTION_DIGITS-1-k)*DIG_W +: DIG_W] =
               (d[k] == 4'd9) ? 4'd0 : d[k] + 4'd1;
         end else begin
            rnd_frac_in[(MAX_FRACTION_DIGITS-1-k)*DIG_W +: DIG_W] = d[k];
         end
         acc = acc && ((k >= int'(p_ff)) || (d[k] == 4'd9));
      end
      carry_int = round_up && acc;

      // integer increment on the BCD digits, least significant first
      acc = carry_int;
      rnd_int_in = '0;
      for (int k = 0; k < BCD_DIGS; k++) begin
         if (acc) begin
            rnd_int_in[k*DIG_W +: DIG_W] = (e[k] == 4'd9) ? 4'd0 : e[k] + 4'd1;
         end else begin
            rnd_int_in[k*DIG_W +: DIG_W] = e[k];
         end
         acc = acc && (e[k] == 4'd9);
      end

      // integer > 2147483647, or rounded past it, pins to it; fraction all nines
      sat = ipart_ff[INT_W-1] || ((ipart_ff == INT_SAT) && carry_int);
      if (sat) begin
         rnd_int_in = INT_SAT_BCD;
         for (int k = 0; k < MAX_FRACTION_DIGITS; k++) begin
            rnd_frac_in[k*DIG_W +: DIG_W] = 4'd9;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ROUND) begin
         rnd_int_ff  <= rnd_int_in;
         rnd_frac_ff <= rnd_frac_in;
      end
   end

   // --- integer digit count: most significant nonzero digit, at least one --
   always_comb begin
      int_len = 4'd1;
      for (int k = 0; k < BCD_DIGS; k++) begin
         if (rnd_int_ff[k*DIG_W +: DIG_W] != 4'd0) begin
            int_len = CNT_W'(k + 1);
         end
      end
   end

   // --- sequencer ----------------------------------------------------------
   assign emit_start = (state_ff == S_LOAD) && !emit_busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (bcd_done && frac_done) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (emit_start) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // --- precision register -------------------------------------------------
   assign prec_in = csr_we ? csr_wdata : prec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prec_ff  <= PREC_RESET;
      end else begin
         state_ff <= state_in;
         prec_ff  <= prec_in;
      end
   end

   // --- character emitter --------------------------------------------------
   assign emit_ctl.neg      = neg_ff;
   assign emit_ctl.int_len  = int_len;
   assign emit_ctl.frac_len = p_ff;

   fda_emit #(
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .start    (emit_start),
      .ctl      (emit_ctl),
      .int_bcd  (rnd_int_ff),
      .frac_bcd (rnd_frac_ff),
      .busy     (emit_busy),
      .rsp_if   (rsp_if)
   );

`ifndef SYNTHESIS
   // an accepted value starts both iterative units
   a_units_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CONV) && !bcd_done && !frac_done)
      else $error("conversion units did not start on accepted value");

   // rounding only sees finished digit strings
   a_round_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (bcd_done && frac_done))
      else $error("rounding entered before conversion finished");

   // rounded integer text fits ten digits
   a_int_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (int_len != 4'd0) && (int_len <= 4'd10))
      else $error("integer digit count out of range");

   // the job is handed over exactly once, then the request side reopens
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      emit_start |=> (state_ff == S_IDLE) && emit_busy)
      else $error("emitter did not take the job");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_fixed_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_to_decimal_ascii_top
// Self-checking bench for the Q31.32 to decimal ASCII converter: drives
// values with random gaps, takes characters with random back-pressure and
// compares each one against a text predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_fixed_to_decimal_ascii_top;
   import fda_pkg::*;

   localparam int MAX_FRAC   = MAX_FRAC_DEFAULT;
   localparam int SETTLE_CYC = 40;     // one full conversion plus margin

   // one expected character of the text
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_we;
   logic [PREC_W-1:0] csr_wdata;

   fda_req_if req_ch ();
   fda_rsp_if rsp_ch ();

   fixed_to_decimal_ascii_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_char_type     text_q[$];        // characters still owed by the block
   logic [PREC_W-1:0] precision_copy;   // bench copy of the precision register
   int                mismatches = 0;
   bit                tx_idle_on = 1'b1;
   bit                rx_idle_on = 1'b1;

   // ------------------------------------------------------------------------
   // Text predictor: appends the full text of one value to text_q.
   // Digits are extracted exactly from the Q31.32 magnitude.
   // ------------------------------------------------------------------------
   function automatic void predict_text(input logic [63:0] raw);
      logic       neg;
      logic       carry;
      logic [63:0] mag;
      logic [63:0] ipart;
      logic [63:0] rem;
      logic [3:0] frac_dig [MAX_FRAC];
      logic [3:0] int_dig [12];
      int         p;
      int         k;
      int         nd;
      text_char_type txt[$];
      neg   = raw[63];
      mag   = neg ? (64'd0 - raw) : raw;   // most negative gives exactly 2^63
      ipart = {32'd0, mag[63:32]};
      rem   = {32'd0, mag[31:0]};

      // precision: negative register picks by decade of the integer part
      if (precision_copy[PREC_W-1]) begin
         if (ipart < 64'd1)           p = 6;
         else if (ipart < 64'd10)     p = 5;
         else if (ipart < 64'd100)    p = 4;
         else if (ipart < 64'd1000)   p = 3;
         else if (ipart < 64'd10000)  p = 2;
         else if (ipart < 64'd100000) p = 1;
         else                         p = 0;
      end else begin
         p = int'(precision_copy);
      end
      if (p > MAX_FRAC) p = MAX_FRAC;

      // fraction digits by repeated times ten
      for (k = 0; k < p; k++) begin
         rem         = rem * 64'd10;
         frac_dig[k] = rem[35:32];
         rem         = rem & 64'h0000_0000_FFFF_FFFF;
      end

      // round half up, only with a nonzero precision; carry may reach ipart
      if (p > 0 && rem >= 64'h8000_0000) begin
         carry = 1'b1;
         for (k = p - 1; k >= 0 && carry; k--) begin
            if (frac_dig[k] == 4'd9) begin
               frac_dig[k] = 4'd0;
            end else begin
               frac_dig[k] = frac_dig[k] + 4'd1;
               carry       = 1'b0;
            end
         end
         if (carry) ipart = ipart + 64'd1;
      end

      // saturation: integer clamps, fraction prints as all nines
      if (ipart > {32'd0, INT_SAT}) begin
         ipart = {32'd0, INT_SAT};
         for (k = 0; k < p; k++) frac_dig[k] = 4'd9;
      end

      if (neg) txt.push_back('{CHAR_MINUS, 1'b0});
      nd = 0;
      do begin
         int_dig[nd] = 4'(ipart % 64'd10);
         ipart       = ipart / 64'd10;
         nd++;
      end while (ipart != 64'd0);
      for (k = nd - 1; k >= 0; k--) txt.push_back('{8'(CHAR_ZERO + int_dig[k]), 1'b0});
      if (p > 0) begin
         txt.push_back('{CHAR_POINT, 1'b0});
         for (k = 0; k < p; k++) txt.push_back('{8'(CHAR_ZERO + frac_dig[k]), 1'b0});
      end
      txt[txt.size() - 1].last = 1'b1;
      foreach (txt[i]) text_q.push_back(txt[i]);
   endfunction

   // Q31.32 from a signed integer part and a raw 32-bit fraction
   function automatic logic [63:0] q32(input logic neg, input logic [31:0] ip,
                                       input logic [31:0] fr);
      logic [63:0] mag;
      mag = {ip, fr};
      return neg ? (64'd0 - mag) : mag;
   endfunction

   // ------------------------------------------------------------------------
   // Request side: one value per call, random gap first if tx_idle_on. valid is
   // left high after the transfer so back-to-back values need no extra edge.
   // ------------------------------------------------------------------------
   task automatic send_value(input logic [63:0] v);
      int gap;
      gap = tx_idle_on ? int'($urandom_range(0, 17)) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      predict_text(v);
   endtask

   // Stop sending, wait for every owed character, then let the block settle.
   task automatic drain_text();
      req_ch.valid <= 1'b0;
      while (text_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Register write, only with nothing in flight.
   task automatic set_precision(input logic [PREC_W-1:0] p);
      drain_text();
      csr_wdata <= p;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we         <= 1'b0;
      precision_copy = p;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stall before each character if rx_idle_on, then
   // check it against the oldest expected character.
   // ------------------------------------------------------------------------
   initial begin
      int            stall;
      text_char_type want;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rx_idle_on ? int'($urandom_range(0, 17)) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
         if (text_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected character: expected none, actual %h last %b",
                     $time, rsp_ch.character, rsp_ch.last);
         end else begin
            want = text_q.pop_front();
            if (rsp_ch.character !== want.character) begin
               mismatches++;
               $display("%0t: character mismatch: expected %h, actual %h",
                        $time, want.character, rsp_ch.character);
            end
            if (rsp_ch.last !== want.last) begin
               mismatches++;
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, want.last, rsp_ch.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Directed: reset precision (2) with the field extremes and the edges.
   // ------------------------------------------------------------------------
   task automatic test_reset_precision();
      send_value(64'd0);
      send_value(q32(1'b0, 32'd1, 32'd0));             // 1.00
      send_value(64'h7FFF_FFFF_FFFF_FFFF);             // rounds past max, saturates
      send_value(64'h8000_0000_0000_0000);             // most negative, saturates
      send_value(64'hFFFF_FFFF_FFFF_FFFF);             // -0.00 keeps its sign
      send_value(q32(1'b0, 32'd0, 32'h2000_0000));     // 0.125, tie rounds up
      send_value(q32(1'b0, 32'd9, 32'hFFFF_FFFF));     // carry into integer: 10.00
      send_value(q32(1'b1, 32'd12, 32'h5851_EB85));    // about -12.345
      drain_text();
   endtask

   // Directed: fixed precisions, zero, tie at one digit, clamp above ten.
   task automatic test_fixed_precision();
      set_precision(5'd0);
      send_value(q32(1'b0, 32'd0, 32'hFFFF_FFFF));     // no rounding at p = 0
      send_value(q32(1'b1, 32'd7, 32'h8000_0000));     // -7
      set_precision(5'd1);
      send_value(q32(1'b0, 32'd0, 32'h4000_0000));     // 0.25 -> 0.3
      set_precision(5'd10);
      send_value(q32(1'b0, 32'd0, 32'h5555_5555));
      send_value(64'h7FFF_FFFF_0000_0001);
      set_precision(5'd15);                            // clamps to ten digits
      send_value(q32(1'b1, 32'd3, 32'h243F_6A89));
      drain_text();
   endtask

   // Directed: automatic precision at each decade boundary.
   task automatic test_auto_precision();
      set_precision(5'h1F);                            // -1
      send_value(q32(1'b0, 32'd0, 32'h8000_0000));
      send_value(q32(1'b0, 32'd9, 32'hFFFF_FFFF));     // rounds to 10 with 5 digits
      send_value(q32(1'b1, 32'd99, 32'h1234_5678));
      send_value(q32(1'b0, 32'd999, 32'hFFFF_0000));
      send_value(q32(1'b0, 32'd9999, 32'h8000_0000));
      send_value(q32(1'b1, 32'd99999, 32'hF000_0000));
      send_value(q32(1'b0, 32'd100000, 32'hFFFF_FFFF)); // no fraction, no rounding
      set_precision(5'h10);                            // -16
      send_value(q32(1'b0, 32'd123, 32'h74BC_6A7F));
      drain_text();
   endtask

   // Random value: full range, small magnitudes, decade edges, exact binary
   // fractions (ties), the saturation zone and values near zero.
   function automatic logic [63:0] pick_value();
      logic [31:0] ip;
      logic [31:0] fr;
      logic [31:0] pw;
      int          s;
      pw = 32'd1;
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: begin
            ip = $urandom_range(0, 200000);
            fr = $urandom;
         end
         2: begin
            repeat ($urandom_range(0, 9)) pw = pw * 32'd10;
            ip = pw - $urandom_range(0, 1);
            fr = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
         end
         3: begin
            s  = $urandom_range(20, 31);
            ip = $urandom_range(0, 1000);
            fr = $urandom & ~((32'd1 << s) - 32'd1);
         end
         4: begin
            ip = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h7FFF_FFFE;
            fr = 32'hFFFF_FFFF - $urandom_range(0, 32'h0100_0000);
         end
         default: begin
            ip = 32'd0;
            fr = $urandom_range(0, 1) ? $urandom_range(0, 255)
                                      : 32'hFFFF_FFFF - $urandom_range(0, 255);
         end
      endcase
      return q32(1'(($urandom_range(0, 1))), ip, fr);
   endfunction

   // Random: phases of random values, each at its own precision and idling.
   task automatic test_random_values();
      logic [PREC_W-1:0] p;
      int                phase;
      int                sent;
      int                n;
      phase = 0;
      sent  = 0;
      while (sent < 260) begin
         // first phases hit the extremes, then anything
         case (phase)
            0:       p = 5'd0;
            1:       p = 5'd10;
            2:       p = 5'h1F;
            3:       p = 5'h10;
            4:       p = 5'd15;
            default: p = PREC_W'($urandom_range(0, 31));
         endcase
         set_precision(p);
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(8, 20);
         repeat (n) send_value(pick_value());
         sent  += n;
         phase++;
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      drain_text();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.value   <= '0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      precision_copy = PREC_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_precision();
      test_fixed_precision();
      test_auto_precision();
      test_random_values();

      if (mismatches == 0) begin
         $display("fixed_to_decimal_ascii_top regression: pass");
      end else begin
         $display("fixed_to_decimal_ascii_top regression: fail");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("fixed_to_decimal_ascii_top regression: fail");
      $finish;
   end

endmodule
